>>> sv/lsai_pkg.sv
`default_nettype none

package lsai_pkg;

  localparam int unsigned TagW   = 16;
  localparam int unsigned CountW = 11;
  localparam int unsigned OffW   = 24;
  localparam int unsigned WayW   = 4;
  localparam int unsigned BktW   = 16;

  localparam logic [CountW-1:0] CountReset = 11'd1024;

  typedef enum logic {
    KIND_LOOKUP = 1'b0,
    KIND_INSERT = 1'b1
  } kind_e;

  typedef struct packed {
    logic            kind;
    logic [63:0]     key_hash;
    logic [OffW-1:0] entry_offset;
  } lsai_in_t;

  typedef struct packed {
    logic            hit;
    logic [OffW-1:0] found_offset;
    logic [WayW-1:0] way_used;
  } lsai_out_t;

  // classified request between front and back
  typedef struct packed {
    logic            kind;
    logic [TagW-1:0] tag;
    logic [BktW-1:0] bucket;
    logic [WayW-1:0] victim;
    logic [OffW-1:0] offset;
  } lsai_req_t;

endpackage

`default_nettype wire

>>> sv/lsai_stream_if.sv
`default_nettype none

interface lsai_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> sv/lsai_front.sv
`default_nettype none

module lsai_front #(
  parameter int unsigned WAYS        = 4,
  parameter int unsigned MAX_BUCKETS = 1024
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      init_done_i,
  input  wire logic [lsai_pkg::CountW-1:0] bucket_count_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire lsai_pkg::lsai_in_t        in_data_i,
  output logic                           push_valid_o,
  input  wire logic                      push_ready_i,
  output lsai_pkg::lsai_req_t            push_data_o
);
  import lsai_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_PUSH
  } state_e;

  localparam int unsigned WayL = (WAYS > 1) ? $clog2(WAYS) : 0;
  localparam int unsigned WayS = TagW + WayL;
  localparam int unsigned WayM = ((32'd1 << WayS) + WAYS - 1) / WAYS;

  // four remainder steps per cycle
  function automatic logic [CountW-1:0] mod_step4(input logic [CountW-1:0] rem,
                                                  input logic [3:0] bits,
                                                  input logic [CountW-1:0] div);
    logic [CountW:0] r;
    r = {1'b0, rem};
    for (int i = 3; i >= 0; i--) begin
      r = {r[CountW-1:0], bits[i]};
      if (r >= {1'b0, div}) begin
        r = r - {1'b0, div};
      end
    end
    return r[CountW-1:0];
  endfunction

  state_e            state_q;
  logic [1:0]        cnt_q;
  logic              accept;
  logic [CountW-1:0] n_eff;
  logic              kind_q;
  logic [TagW-1:0]   tag_q;
  logic [15:0]       sel_q;
  logic [TagW-1:0]   quo_q;
  logic [OffW-1:0]   off_q;
  logic [CountW-1:0] div_q;
  logic [CountW-1:0] remb_q;
  logic [CountW-1:0] remw_q;
  logic [33:0]       wprod;
  logic [TagW-1:0]   wquo;
  logic [TagW-1:0]   wrem;

  always_comb begin
    if (bucket_count_i == '0) begin
      n_eff = 11'd1;
    end else if ({6'd0, bucket_count_i} > 17'(MAX_BUCKETS)) begin
      n_eff = CountW'(MAX_BUCKETS);
    end else begin
      n_eff = bucket_count_i;
    end
  end

  // tag mod WAYS by reciprocal multiply, quotient then remainder
  assign wprod = {18'd0, tag_q} * 34'(WayM);
  assign wquo  = TagW'(wprod >> WayS);
  assign wrem  = tag_q - quo_q * TagW'(WAYS);

  assign in_ready_o = init_done_i &&
                      (state_q == S_IDLE || (state_q == S_PUSH && push_ready_i));
  assign accept = in_valid_i && in_ready_o;

  assign push_valid_o       = (state_q == S_PUSH);
  assign push_data_o.kind   = kind_q;
  assign push_data_o.tag    = tag_q;
  assign push_data_o.bucket = BktW'(remb_q);
  assign push_data_o.victim = WayW'(remw_q);
  assign push_data_o.offset = off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_DIV;
            cnt_q   <= '0;
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            state_q <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (push_ready_i) begin
            state_q <= accept ? S_DIV : S_IDLE;
            cnt_q   <= '0;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= in_data_i.kind;
      tag_q  <= in_data_i.key_hash[15:0];
      sel_q  <= in_data_i.key_hash[31:16];
      off_q  <= in_data_i.entry_offset;
      div_q  <= n_eff;
      remb_q <= '0;
      remw_q <= '0;
    end else if (state_q == S_DIV) begin
      remb_q <= mod_step4(remb_q, sel_q[15:12], div_q);
      quo_q  <= wquo;
      remw_q <= CountW'(wrem);
      sel_q  <= {sel_q[11:0], 4'd0};
    end
  end

endmodule

`default_nettype wire

>>> sv/lsai_queue.sv
`default_nettype none

module lsai_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_valid_i,
  output logic                     push_ready_o,
  input  wire lsai_pkg::lsai_req_t push_data_i,
  output logic                     pop_valid_o,
  input  wire logic                pop_ready_i,
  output lsai_pkg::lsai_req_t      pop_data_o
);
  import lsai_pkg::*;

  lsai_req_t  slot_q [2];
  logic       wptr_q;
  logic       rptr_q;
  logic [1:0] cnt_q;
  logic       push;
  logic       pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = slot_q[rptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> sv/lsai_back.sv
`default_nettype none

module lsai_back #(
  parameter int unsigned WAYS        = 4,
  parameter int unsigned MAX_BUCKETS = 1024,
  parameter int unsigned OFFSET_BITS = 24
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  output logic                     init_done_o,
  input  wire logic                pop_valid_i,
  output logic                     pop_ready_o,
  input  wire lsai_pkg::lsai_req_t pop_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output lsai_pkg::lsai_out_t      out_data_o
);
  import lsai_pkg::*;

  localparam int unsigned BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned SW = (OFFSET_BITS < OffW) ? OFFSET_BITS : OffW;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL
  } state_e;

  logic [WAYS-1:0]                vld_mem [MAX_BUCKETS];
  logic [WAYS-1:0][TagW-1:0]      tag_mem [MAX_BUCKETS];
  logic [WAYS-1:0][SW-1:0]        off_mem [MAX_BUCKETS];

  state_e                    state_q;
  logic [BW-1:0]             clr_addr_q;
  lsai_req_t                 req_q;
  logic [WAYS-1:0]           vld_rd_q;
  logic [WAYS-1:0][TagW-1:0] tag_rd_q;
  logic [WAYS-1:0][SW-1:0]   off_rd_q;
  logic                      out_valid_q;
  lsai_out_t                 out_q;

  logic                      pop;
  logic [BW-1:0]             rd_addr;
  logic [BW-1:0]             row_addr;
  logic                      lk_hit;
  logic [WW-1:0]             lk_way;
  logic                      ins_found;
  logic [WW-1:0]             ins_way;
  logic [WW-1:0]             wr_way;
  logic [WAYS-1:0]           vld_wd;
  logic [WAYS-1:0][TagW-1:0] tag_wd;
  logic [WAYS-1:0][SW-1:0]   off_wd;
  logic                      row_we;
  lsai_out_t                 res;

  assign init_done_o = (state_q != S_CLEAR);
  assign pop_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign pop         = pop_valid_i && pop_ready_o;
  assign rd_addr     = pop_data_i.bucket[BW-1:0];
  assign row_addr    = req_q.bucket[BW-1:0];
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign row_we      = (state_q == S_EVAL) && (req_q.kind == KIND_INSERT);

  // first matching way, first free-or-matching way
  always_comb begin
    lk_hit    = 1'b0;
    lk_way    = '0;
    ins_found = 1'b0;
    ins_way   = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (vld_rd_q[w] && tag_rd_q[w] == req_q.tag) begin
        lk_hit = 1'b1;
        lk_way = WW'(w);
      end
      if (!vld_rd_q[w] || tag_rd_q[w] == req_q.tag) begin
        ins_found = 1'b1;
        ins_way   = WW'(w);
      end
    end
  end

  always_comb begin
    wr_way         = ins_found ? ins_way : req_q.victim[WW-1:0];
    vld_wd         = vld_rd_q;
    tag_wd         = tag_rd_q;
    off_wd         = off_rd_q;
    vld_wd[wr_way] = 1'b1;
    tag_wd[wr_way] = req_q.tag;
    off_wd[wr_way] = req_q.offset[SW-1:0];
    res            = '0;
    if (req_q.kind == KIND_INSERT) begin
      res.way_used = WayW'(wr_way);
    end else if (lk_hit) begin
      res.hit          = 1'b1;
      res.found_offset = OffW'(off_rd_q[lk_way]);
      res.way_used     = WayW'(lk_way);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          clr_addr_q <= clr_addr_q + BW'(1);
          if (clr_addr_q == BW'(MAX_BUCKETS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop) begin
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      if (state_q == S_EVAL) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      req_q <= pop_data_i;
    end
    if (state_q == S_EVAL) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) begin
      vld_mem[clr_addr_q] <= '0;
    end else if (row_we) begin
      vld_mem[row_addr] <= vld_wd;
    end
    vld_rd_q <= vld_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (row_we) begin
      tag_mem[row_addr] <= tag_wd;
    end
    tag_rd_q <= tag_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (row_we) begin
      off_mem[row_addr] <= off_wd;
    end
    off_rd_q <= off_mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> sv/lossy_set_assoc_tag_index.sv
// Lossy set-associative index of log offsets. A request either looks up or
// inserts under a 64-bit key hash: bits 31..16 modulo the bucket count pick
// a bucket of WAYS ways, bits 15..0 are the tag. An insert takes the first
// empty or same-tag way, otherwise way (tag mod WAYS) is overwritten. After
// reset the block clears the valid bits of every bucket and takes no
// request meanwhile. A request then passes through the front, where the
// bucket remainder unit works through the selector 4 bits per cycle,
// before its hand-off to the queue; the front takes a new request only
// while idle or in the cycle it hands the last one on. The back reads the
// row, writes it back for an insert, and takes no new request until done.
// Write bucket_count only when no request is in flight.
`default_nettype none

module lossy_set_assoc_tag_index #(
  parameter int unsigned WAYS        = 4,
  parameter int unsigned MAX_BUCKETS = 1024,
  parameter int unsigned OFFSET_BITS = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [lsai_pkg::CountW-1:0]   cfg_wdata_i,
  lsai_stream_if.sink                        req_i,
  lsai_stream_if.source                      rsp_o
);
  import lsai_pkg::*;

  logic [CountW-1:0] bucket_count_q;
  logic              init_done;
  logic              push_valid;
  logic              push_ready;
  lsai_req_t         push_data;
  logic              pop_valid;
  logic              pop_ready;
  lsai_req_t         pop_data;
  lsai_in_t          in_data;
  lsai_out_t         out_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= CountReset;
    end else if (cfg_we_i) begin
      bucket_count_q <= cfg_wdata_i;
    end
  end

  assign in_data       = req_i.payload;
  assign rsp_o.payload = out_data;

  lsai_front #(
    .WAYS        (WAYS),
    .MAX_BUCKETS (MAX_BUCKETS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .init_done_i    (init_done),
    .bucket_count_i (bucket_count_q),
    .in_valid_i     (req_i.valid),
    .in_ready_o     (req_i.ready),
    .in_data_i      (in_data),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_data_o    (push_data)
  );

  lsai_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  lsai_back #(
    .WAYS        (WAYS),
    .MAX_BUCKETS (MAX_BUCKETS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .init_done_o (init_done),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .out_data_o  (out_data)
  );

endmodule

`default_nettype wire

>>> sv/lsai_checker.sv
`default_nettype none

module lsai_checker #(
  parameter int unsigned WAYS = 4
) (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      req_valid_i,
  input wire logic                      req_ready_i,
  input wire logic                      rsp_valid_i,
  input wire logic                      rsp_ready_i,
  input wire logic                      rsp_hit_i,
  input wire logic [lsai_pkg::OffW-1:0] rsp_found_offset_i,
  input wire logic [lsai_pkg::WayW-1:0] rsp_way_used_i
);
  import lsai_pkg::*;

  logic [3:0] open_q;
  logic       req_acc;
  logic       rsp_acc;

  assign req_acc = req_valid_i && req_ready_i;
  assign rsp_acc = rsp_valid_i && rsp_ready_i;

  // requests in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else if (req_acc && !rsp_acc) begin
      open_q <= open_q + 4'd1;
    end else if (rsp_acc && !req_acc) begin
      open_q <= open_q - 4'd1;
    end
  end

  a_no_orphan_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> open_q != 4'd0)
    else $error("response without open request");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_hit_i |-> rsp_found_offset_i == '0)
    else $error("offset reported without hit");

  a_way_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> {1'b0, rsp_way_used_i} < 5'(WAYS))
    else $error("way out of range");

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !req_ready_i)
    else $error("request taken during clear");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_hit_i) &&
      $stable(rsp_found_offset_i) && $stable(rsp_way_used_i))
    else $error("stalled response changed");

endmodule

bind lossy_set_assoc_tag_index lsai_checker #(
  .WAYS (WAYS)
) u_lsai_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid_i        (req_i.valid),
  .req_ready_i        (req_i.ready),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .rsp_hit_i          (rsp_o.payload.hit),
  .rsp_found_offset_i (rsp_o.payload.found_offset),
  .rsp_way_used_i     (rsp_o.payload.way_used)
);

`default_nettype wire

>>> verif/tb_lossy_set_assoc_tag_index.sv
`timescale 1ns / 100ps

module tb_lossy_set_assoc_tag_index;
  import lsai_pkg::*;

  localparam int unsigned NumWays    = 4;
  localparam int unsigned MaxBuckets = 1024;
  localparam int unsigned NumSlots   = NumWays * MaxBuckets;
  localparam int unsigned MaxGap     = 16;
  localparam int unsigned HoldAt     = 250;
  localparam int unsigned LongHold   = 400;
  localparam int unsigned DrainWait  = 12;
  localparam int unsigned NumPhases  = 8;
  localparam int unsigned PhaseItems = 156;
  localparam int unsigned PoolSize   = 20;
  localparam time         RunLimit   = 5ms;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [CountW-1:0] cfg_wdata_i;

  lsai_stream_if #(.payload_t(lsai_in_t))  req_if ();
  lsai_stream_if #(.payload_t(lsai_out_t)) rsp_if ();

  lossy_set_assoc_tag_index u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // index state as the block should hold it
  bit               slot_valid [NumSlots];
  logic [TagW-1:0]  slot_tag   [NumSlots];
  logic [OffW-1:0]  slot_offset[NumSlots];
  logic [CountW-1:0] bucket_count_cfg = CountReset;

  lsai_in_t  request_q[$];
  lsai_out_t expected_rsp_q[$];
  logic [63:0] key_pool[PoolSize];

  int unsigned n_errors = 0;
  int unsigned n_lookups = 0;
  int unsigned n_hits = 0;
  int unsigned n_inserts = 0;
  int unsigned n_evictions = 0;
  int unsigned n_settings = 0;
  int unsigned rsp_seen = 0;
  bit          gaps_on = 1'b1;

  function automatic lsai_out_t index_predict(lsai_in_t rq);
    lsai_out_t       res;
    int unsigned     n;
    int unsigned     sel;
    int unsigned     base;
    int unsigned     victim;
    logic [TagW-1:0] tg;
    bit              found;
    res = '0;
    n = 32'(bucket_count_cfg);
    if (n == 0) n = 1;
    if (n > MaxBuckets) n = MaxBuckets;
    sel = 32'(rq.key_hash[31:16]);
    base = (sel % n) * NumWays;
    tg = rq.key_hash[15:0];
    found = 1'b0;
    if (kind_e'(rq.kind) == KIND_LOOKUP) begin
      n_lookups++;
      for (int w = 0; w < NumWays; w++) begin
        if (!found && slot_valid[base+w] && slot_tag[base+w] == tg) begin
          found = 1'b1;
          res.hit = 1'b1;
          res.found_offset = slot_offset[base+w];
          res.way_used = WayW'(w);
        end
      end
      if (found) n_hits++;
    end else begin
      n_inserts++;
      victim = 32'(tg) % NumWays;
      for (int w = 0; w < NumWays; w++) begin
        if (!found && (!slot_valid[base+w] || slot_tag[base+w] == tg)) begin
          found = 1'b1;
          victim = w;
        end
      end
      if (!found) n_evictions++;
      slot_valid[base+victim] = 1'b1;
      slot_tag[base+victim] = tg;
      slot_offset[base+victim] = rq.entry_offset;
      res.way_used = WayW'(victim);
    end
    return res;
  endfunction

  task automatic report_mismatch(string what);
    n_errors++;
    $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  // driver
  int unsigned req_gap = 0;
  bit          req_fire;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.payload <= '0;
      req_gap = 0;
    end else begin
      req_fire = req_if.valid && req_if.ready;
      if (req_fire) begin
        expected_rsp_q.push_back(index_predict(req_if.payload));
        req_gap = gaps_on ? $urandom_range(0, MaxGap) : 0;
      end
      if (req_if.valid && !req_fire) begin
        // hold the offered request
      end else if (req_gap > 0) begin
        req_gap--;
        req_if.valid <= 1'b0;
      end else if (request_q.size() > 0) begin
        req_if.payload <= request_q.pop_front();
        req_if.valid <= 1'b1;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // monitor
  int unsigned rsp_stall = 0;
  int unsigned rsp_hold = 0;
  lsai_out_t   rsp_want;
  lsai_out_t   rsp_got;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      rsp_stall = 0;
      rsp_hold = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        rsp_got = rsp_if.payload;
        rsp_seen++;
        if (expected_rsp_q.size() == 0) begin
          report_mismatch($sformatf("response with nothing pending: hit %0b off %06h way %0d",
                                    rsp_got.hit, rsp_got.found_offset, rsp_got.way_used));
        end else begin
          rsp_want = expected_rsp_q.pop_front();
          if (rsp_got.hit !== rsp_want.hit)
            report_mismatch($sformatf("response %0d hit %0b, want %0b",
                                      rsp_seen, rsp_got.hit, rsp_want.hit));
          if (rsp_got.found_offset !== rsp_want.found_offset)
            report_mismatch($sformatf("response %0d found_offset %06h, want %06h",
                                      rsp_seen, rsp_got.found_offset, rsp_want.found_offset));
          if (rsp_got.way_used !== rsp_want.way_used)
            report_mismatch($sformatf("response %0d way_used %0d, want %0d",
                                      rsp_seen, rsp_got.way_used, rsp_want.way_used));
        end
        rsp_stall = gaps_on ? $urandom_range(0, MaxGap) : 0;
        if (rsp_seen == HoldAt) rsp_hold = LongHold;
      end else if (rsp_stall > 0) begin
        rsp_stall--;
      end
      if (rsp_hold > 0) rsp_hold--;
      rsp_if.ready <= (rsp_stall == 0) && (rsp_hold == 0);
    end
  end

  function automatic logic [63:0] compose_hash(logic [15:0] bsel, logic [15:0] tg);
    return {32'($urandom), bsel, tg};
  endfunction

  function automatic void push_req(kind_e k, logic [63:0] h, logic [OffW-1:0] off);
    lsai_in_t rq;
    rq.kind = k;
    rq.key_hash = h;
    rq.entry_offset = off;
    request_q.push_back(rq);
  endfunction

  function automatic logic [OffW-1:0] draw_offset();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return OffW'($urandom);
    endcase
  endfunction

  // keys crowd a few buckets and tags so hits, same-tag updates and evictions all happen
  function automatic void fill_key_pool();
    logic [15:0] bsel;
    logic [15:0] tg;
    for (int i = 0; i < PoolSize; i++) begin
      case ($urandom_range(0, 3))
        0: bsel = 16'($urandom);
        1: bsel = 16'h8000 | 16'($urandom_range(0, 5));
        default: bsel = 16'($urandom_range(0, 5));
      endcase
      tg = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 9));
      key_pool[i] = compose_hash(bsel, tg);
    end
  endfunction

  function automatic void queue_random_phase(int unsigned n);
    logic [63:0] h;
    fill_key_pool();
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) h = {32'($urandom), 32'($urandom)};
      else h = key_pool[$urandom_range(0, PoolSize - 1)];
      push_req(kind_e'($urandom_range(0, 1)), h, draw_offset());
    end
  endfunction

  task automatic wait_drained();
    do @(negedge clk_i);
    while (request_q.size() != 0 || req_if.valid || expected_rsp_q.size() != 0);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic write_bucket_count(logic [CountW-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    bucket_count_cfg = value;
    n_settings++;
    @(negedge clk_i);
  endtask

  logic [CountW-1:0] count_plan[NumPhases];

  initial begin
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part under the reset bucket count
    push_req(KIND_LOOKUP, 64'h0, '0);
    push_req(KIND_INSERT, 64'h0, '0);
    push_req(KIND_LOOKUP, 64'h0, '1);
    push_req(KIND_INSERT, '1, '1);
    push_req(KIND_LOOKUP, '1, '0);
    push_req(KIND_INSERT, compose_hash(16'h0000, 16'h0000), 24'h123456);
    push_req(KIND_LOOKUP, compose_hash(16'h0000, 16'h0000), '0);
    push_req(KIND_INSERT, compose_hash(16'h0005, 16'd1), 24'd11);
    push_req(KIND_INSERT, compose_hash(16'h8005, 16'd2), 24'd22);
    push_req(KIND_INSERT, compose_hash(16'h0405, 16'd3), 24'd33);
    push_req(KIND_INSERT, compose_hash(16'hFC05, 16'd4), 24'd44);
    push_req(KIND_INSERT, compose_hash(16'h0005, 16'd6), 24'd66);
    push_req(KIND_LOOKUP, compose_hash(16'h0005, 16'd3), '1);
    push_req(KIND_LOOKUP, compose_hash(16'h0005, 16'd6), '0);
    push_req(KIND_LOOKUP, compose_hash(16'h8005, 16'd4), '0);
    push_req(KIND_LOOKUP, compose_hash(16'h0005, 16'd1), '0);
    push_req(KIND_LOOKUP, compose_hash(16'h0006, 16'd1), '0);
    push_req(KIND_INSERT, compose_hash(16'hFFFF, 16'hFFFF), 24'h000001);
    wait_drained();

    count_plan = '{11'd1, 11'd0, 11'd2047, 11'd3, 11'd1024, 11'd1025,
                   11'($urandom_range(2, 64)), 11'd7};
    for (int p = 0; p < NumPhases; p++) begin
      write_bucket_count(count_plan[p]);
      gaps_on = (p % 3) != 1;
      queue_random_phase(PhaseItems);
      wait_drained();
    end

    $display("covered %0d requests: %0d lookups (%0d hits), %0d inserts (%0d evictions)",
             n_lookups + n_inserts, n_lookups, n_hits, n_inserts, n_evictions);
    $display("across %0d bucket-count settings plus the reset value, incl. 0, 1 and 2047",
             n_settings);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(RunLimit);
    $display("timeout with %0d responses outstanding", expected_rsp_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> filelist.f
sv/lsai_pkg.sv
sv/lsai_stream_if.sv
sv/lsai_front.sv
sv/lsai_queue.sv
sv/lsai_back.sv
sv/lossy_set_assoc_tag_index.sv
sv/lsai_checker.sv
verif/tb_lossy_set_assoc_tag_index.sv
